FILE: design/pentadiagonal_stencil_spmv_core_macros.svh
// Assertion macros shared by the pentadiagonal stencil SpMV design files
`ifndef PENTADIAGONAL_STENCIL_SPMV_CORE_MACROS_SVH
`define PENTADIAGONAL_STENCIL_SPMV_CORE_MACROS_SVH

// same-cycle implication, disabled in reset
`define PDSS_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("pdss assertion failed");

// next-cycle implication, disabled in reset
`define PDSS_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("pdss assertion failed");

`endif

FILE: design/pdss_pkg.sv
// Shared types and constants for the pentadiagonal stencil SpMV core
package pdss_pkg;

    localparam int DEF_MAX_ELEMENTS = 4096;
    localparam int TAP_COUNT        = 5;
    localparam int TAP_W            = 3;
    localparam int INDEX_W          = 12;
    localparam int DATA_W           = 32;
    localparam int VEC_SIZE_W       = 13;
    localparam int STRIDE_W         = 12;
    localparam int CFG_INDEX_W      = 4;
    localparam int CFG_DATA_W       = 13;
    localparam int PROD_W           = 64;
    localparam int SUM_W            = 67;
    localparam int FRAC_W           = 16;

    localparam logic CMD_LOAD    = 1'b0;
    localparam logic CMD_COMPUTE = 1'b1;

    localparam logic [CFG_INDEX_W-1:0] REG_VEC_SIZE = 4'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_STRIDE   = 4'd1;

    localparam logic [VEC_SIZE_W-1:0] VEC_SIZE_RESET = 13'd4096;
    localparam logic [STRIDE_W-1:0]   STRIDE_RESET   = 12'd64;

    localparam logic [TAP_W-1:0] TAP_FAR_BELOW = 3'd0;
    localparam logic [TAP_W-1:0] TAP_LEFT      = 3'd1;
    localparam logic [TAP_W-1:0] TAP_CENTER    = 3'd2;
    localparam logic [TAP_W-1:0] TAP_RIGHT     = 3'd3;
    localparam logic [TAP_W-1:0] TAP_FAR_ABOVE = 3'd4;

    typedef logic signed [PROD_W-1:0] prod_t;

    typedef struct packed {
        logic                     cmd;
        logic [INDEX_W-1:0]       index;
        logic signed [DATA_W-1:0] vec_value;
        logic signed [DATA_W-1:0] coef_far_below;
        logic signed [DATA_W-1:0] coef_left;
        logic signed [DATA_W-1:0] coef_center;
        logic signed [DATA_W-1:0] coef_right;
        logic signed [DATA_W-1:0] coef_far_above;
    } in_item_t;

    typedef struct packed {
        logic [INDEX_W-1:0]       row;
        logic signed [DATA_W-1:0] result_value;
        logic                     saturated;
        logic                     row_error;
    } out_item_t;

    typedef struct packed {
        logic               go;
        logic [INDEX_W-1:0] row;
        logic               err;
    } merge_ctl_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_READ,
        ST_DRAIN
    } st_t;

endpackage

FILE: design/pdss_lane.sv
// One multiply lane: holds a row coefficient and forms its product with a neighbour
module pdss_lane
    import pdss_pkg::*;
(
    input  logic                     clk,
    input  logic                     coef_load,
    input  logic signed [DATA_W-1:0] coef_in,
    input  logic                     cap,
    input  logic                     tap_ok,
    input  logic signed [DATA_W-1:0] vec_in,
    output prod_t                    prod
);

    logic signed [DATA_W-1:0] coef_reg;
    prod_t                    prod_reg;
    prod_t                    prod_next;

    assign prod_next = coef_reg * vec_in;

    always_ff @(posedge clk)
    begin
        if (coef_load)
        begin
            coef_reg <= coef_in;
        end
        if (cap)
        begin
            prod_reg <= tap_ok ? prod_next : '0;
        end
    end

    assign prod = prod_reg;

endmodule

FILE: design/pdss_merge.sv
// Merging stage: adds the lane products, truncates to Q16.16 and saturates
`include "pentadiagonal_stencil_spmv_core_macros.svh"
module pdss_merge
    import pdss_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  merge_ctl_t ctl,
    input  prod_t      prods [TAP_COUNT],
    output logic       done,
    output out_item_t  result
);

    localparam int TOT_W = SUM_W - FRAC_W;

    logic signed [SUM_W-1:0] s01_reg;
    logic signed [SUM_W-1:0] s23_reg;
    logic signed [SUM_W-1:0] p4_reg;
    logic                    v1_reg;
    logic [INDEX_W-1:0]      row1_reg;
    logic                    err1_reg;

    logic signed [SUM_W-1:0] sum;
    logic signed [TOT_W-1:0] tot;
    logic                    in_range;
    out_item_t               res_next;
    out_item_t               res_reg;
    logic                    done_reg;

    always_ff @(posedge clk)
    begin
        s01_reg  <= SUM_W'(prods[0]) + SUM_W'(prods[1]);
        s23_reg  <= SUM_W'(prods[2]) + SUM_W'(prods[3]);
        p4_reg   <= SUM_W'(prods[4]);
        row1_reg <= ctl.row;
        err1_reg <= ctl.err;
    end

    assign sum      = s01_reg + s23_reg + p4_reg;
    assign tot      = sum[SUM_W-1:FRAC_W];
    assign in_range = (&tot[TOT_W-1:DATA_W-1]) || !(|tot[TOT_W-1:DATA_W-1]);

    always_comb
    begin
        res_next.row       = row1_reg;
        res_next.row_error = err1_reg;
        if (err1_reg)
        begin
            res_next.result_value = '0;
            res_next.saturated    = 1'b0;
        end
        else if (in_range)
        begin
            res_next.result_value = tot[DATA_W-1:0];
            res_next.saturated    = 1'b0;
        end
        else
        begin
            res_next.result_value = tot[TOT_W-1] ? {1'b1, {(DATA_W-1){1'b0}}}
                                                 : {1'b0, {(DATA_W-1){1'b1}}};
            res_next.saturated    = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg   <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            v1_reg   <= ctl.go;
            done_reg <= v1_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (v1_reg)
        begin
            res_reg <= res_next;
        end
    end

    assign done   = done_reg;
    assign result = res_reg;

    `PDSS_ASSERT_NXT(a_merge_flow, clk, rst_n, ctl.go, v1_reg)
    `PDSS_ASSERT_NXT(a_done_follows, clk, rst_n, v1_reg, done)
    `PDSS_ASSERT_IMP(a_err_zero, clk, rst_n, done && result.row_error, result.result_value == 0)
    `PDSS_ASSERT_IMP(a_err_nosat, clk, rst_n, done && result.row_error, !result.saturated)

endmodule

FILE: design/pentadiagonal_stencil_spmv_core.sv
// Top level: vector store, tap sequencer, five multiply lanes and merge stage
// Load item: written at its accepting edge; busy stays low, one load per cycle.
// Compute item: busy through five reads on the one store read port and one drain,
//   one row at a time; done via go_reg, v1_reg, done_reg. Out-of-range row: no reads.
// Reset (rst_n low, async) clears control, vec_size to 4096, stride to 64; store kept.
`include "pentadiagonal_stencil_spmv_core_macros.svh"
module pentadiagonal_stencil_spmv_core
    import pdss_pkg::*;
#(
    parameter int MAX_ELEMENTS = DEF_MAX_ELEMENTS
)(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   start,
    output logic                   busy,
    input  in_item_t               item,
    output logic                   done,
    output out_item_t              result,
    input  logic                   cfg_valid,
    output logic                   cfg_ready,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data
);

    localparam int AW = $clog2(MAX_ELEMENTS);

    logic [DATA_W-1:0] mem [MAX_ELEMENTS];

    st_t                   state_reg;
    st_t                   state_next;
    logic [TAP_W-1:0]      tap_reg;
    logic [TAP_W-1:0]      tap_next;
    logic [INDEX_W-1:0]    row_reg;
    logic [INDEX_W-1:0]    row_next;
    logic                  go_reg;
    logic                  go_next;
    logic                  err_reg;
    logic                  err_next;
    logic [VEC_SIZE_W-1:0] vec_size_reg;
    logic [STRIDE_W-1:0]   stride_reg;
    logic                  cap_valid_reg;
    logic [TAP_W-1:0]      cap_tap_reg;
    logic                  cap_ok_reg;
    logic [DATA_W-1:0]     rdata_reg;

    logic                  accept;
    logic                  in_range;
    logic                  we;
    logic                  rd_en;
    logic [VEC_SIZE_W-1:0] size_eff;
    logic [VEC_SIZE_W-1:0] row13;
    logic [VEC_SIZE_W-1:0] str13;
    logic [VEC_SIZE_W-1:0] nbr;
    logic                  tap_ok;
    logic                  coef_load;
    logic                  last_cap;
    logic signed [DATA_W-1:0] coefs [TAP_COUNT];
    prod_t                 prods [TAP_COUNT];
    merge_ctl_t            ctl;

    assign busy      = state_reg != ST_IDLE;
    assign accept    = start && !busy;
    assign cfg_ready = 1'b1;
    assign coef_load = accept && item.cmd == CMD_COMPUTE;

    assign size_eff = (32'(vec_size_reg) > MAX_ELEMENTS) ? VEC_SIZE_W'(MAX_ELEMENTS)
                                                        : vec_size_reg;
    assign in_range = {1'b0, item.index} < size_eff;

    assign row13 = {1'b0, row_reg};
    assign str13 = {1'b0, stride_reg};

    always_comb
    begin
        case (tap_reg)
            TAP_FAR_BELOW:
            begin
                nbr    = row13 - str13;
                tap_ok = row13 >= str13;
            end
            TAP_LEFT:
            begin
                nbr    = row13 - 13'd1;
                tap_ok = row13 != '0;
            end
            TAP_CENTER:
            begin
                nbr    = row13;
                tap_ok = 1'b1;
            end
            TAP_RIGHT:
            begin
                nbr    = row13 + 13'd1;
                tap_ok = nbr < size_eff;
            end
            TAP_FAR_ABOVE:
            begin
                nbr    = row13 + str13;
                tap_ok = nbr < size_eff;
            end
            default:
            begin
                nbr    = row13;
                tap_ok = 1'b0;
            end
        endcase
    end

    always_comb
    begin
        state_next = state_reg;
        tap_next   = tap_reg;
        row_next   = row_reg;
        go_next    = 1'b0;
        err_next   = err_reg;
        we         = 1'b0;
        rd_en      = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    if (item.cmd == CMD_LOAD)
                    begin
                        we = 32'(item.index) < MAX_ELEMENTS;
                    end
                    else
                    begin
                        row_next = item.index;
                        if (in_range)
                        begin
                            state_next = ST_READ;
                            tap_next   = TAP_FAR_BELOW;
                            err_next   = 1'b0;
                        end
                        else
                        begin
                            go_next  = 1'b1;
                            err_next = 1'b1;
                        end
                    end
                end
            end
            ST_READ:
            begin
                rd_en = 1'b1;
                if (tap_reg == TAP_FAR_ABOVE)
                begin
                    state_next = ST_DRAIN;
                end
                else
                begin
                    tap_next = tap_reg + 3'd1;
                end
            end
            ST_DRAIN:
            begin
                state_next = ST_IDLE;
                go_next    = 1'b1;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            tap_reg       <= TAP_FAR_BELOW;
            row_reg       <= '0;
            go_reg        <= 1'b0;
            err_reg       <= 1'b0;
            cap_valid_reg <= 1'b0;
            cap_tap_reg   <= TAP_FAR_BELOW;
            cap_ok_reg    <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            tap_reg       <= tap_next;
            row_reg       <= row_next;
            go_reg        <= go_next;
            err_reg       <= err_next;
            cap_valid_reg <= rd_en;
            cap_tap_reg   <= tap_reg;
            cap_ok_reg    <= tap_ok;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vec_size_reg <= VEC_SIZE_RESET;
            stride_reg   <= STRIDE_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                REG_VEC_SIZE: vec_size_reg <= cfg_data;
                REG_STRIDE:   stride_reg   <= cfg_data[STRIDE_W-1:0];
                default:      ;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[AW'(item.index)] <= item.vec_value;
        end
        if (rd_en)
        begin
            rdata_reg <= mem[AW'(nbr)];
        end
    end

    assign coefs[0] = item.coef_far_below;
    assign coefs[1] = item.coef_left;
    assign coefs[2] = item.coef_center;
    assign coefs[3] = item.coef_right;
    assign coefs[4] = item.coef_far_above;

    for (genvar g = 0; g < TAP_COUNT; g++)
    begin : g_lane
        pdss_lane u_lane (
            .clk       (clk),
            .coef_load (coef_load),
            .coef_in   (coefs[g]),
            .cap       (cap_valid_reg && cap_tap_reg == TAP_W'(g)),
            .tap_ok    (cap_ok_reg),
            .vec_in    (rdata_reg),
            .prod      (prods[g])
        );
    end

    assign ctl.go  = go_reg;
    assign ctl.row = row_reg;
    assign ctl.err = err_reg;

    pdss_merge u_merge (
        .clk    (clk),
        .rst_n  (rst_n),
        .ctl    (ctl),
        .prods  (prods),
        .done   (done),
        .result (result)
    );

    assign last_cap = cap_valid_reg && cap_tap_reg == TAP_FAR_ABOVE;

    `PDSS_ASSERT_NXT(a_compute_busy, clk, rst_n, coef_load && in_range, busy)
    `PDSS_ASSERT_NXT(a_drain_go, clk, rst_n, state_reg == ST_DRAIN, go_reg)
    `PDSS_ASSERT_IMP(a_drain_last_tap, clk, rst_n, state_reg == ST_DRAIN, last_cap)

endmodule

FILE: verif/stencil_scoreboard_pkg.sv
// Scoreboard class: expected stencil row sums and the vector copy they are built from
`timescale 1ns / 1ps
package stencil_scoreboard_pkg;
    import pdss_pkg::*;

    localparam logic signed [SUM_W-1:0] Q16_MAX = 67'sd2147483647;
    localparam logic signed [SUM_W-1:0] Q16_MIN = -67'sd2147483648;

    class stencil_scoreboard;
        logic signed [DATA_W-1:0] vec_mem [DEF_MAX_ELEMENTS];
        bit                       loaded [DEF_MAX_ELEMENTS];
        int                       vec_size_reg;
        int                       stride_reg;
        out_item_t                rows_due [$];
        int                       mismatches;
        int                       loads;
        int                       computes;
        int                       rows_checked;
        int                       row_errors;
        int                       clipped;

        function new();
            vec_size_reg = int'(VEC_SIZE_RESET);
            stride_reg   = int'(STRIDE_RESET);
            mismatches   = 0;
            loads        = 0;
            computes     = 0;
            rows_checked = 0;
            row_errors   = 0;
            clipped      = 0;
        endfunction

        function int live_size();
            return (vec_size_reg > DEF_MAX_ELEMENTS) ? DEF_MAX_ELEMENTS : vec_size_reg;
        endfunction

        // offsets -stride, -1, 0, +1, +stride
        function int tap_offset(int t);
            case (t)
                int'(TAP_FAR_BELOW): return -stride_reg;
                int'(TAP_LEFT):      return -1;
                int'(TAP_RIGHT):     return 1;
                int'(TAP_FAR_ABOVE): return stride_reg;
                default:             return 0;
            endcase
        endfunction

        function void set_reg(logic [CFG_INDEX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
            if (idx == REG_VEC_SIZE)
                vec_size_reg = int'(data);
            else if (idx == REG_STRIDE)
                stride_reg = int'(data[STRIDE_W-1:0]);
        endfunction

        function out_item_t stencil_row(in_item_t it);
            out_item_t                r;
            logic signed [SUM_W-1:0]  acc;
            logic signed [SUM_W-1:0]  coef;
            logic signed [SUM_W-1:0]  elem;
            logic signed [SUM_W-1:0]  q;
            logic signed [DATA_W-1:0] coefs [TAP_COUNT];
            int                       size;
            int                       j;
            int                       t;
            size           = live_size();
            r.row          = it.index;
            r.result_value = '0;
            r.saturated    = 1'b0;
            r.row_error    = 1'b0;
            if (int'(it.index) >= size)
            begin
                r.row_error = 1'b1;
                return r;
            end
            coefs[TAP_FAR_BELOW] = it.coef_far_below;
            coefs[TAP_LEFT]      = it.coef_left;
            coefs[TAP_CENTER]    = it.coef_center;
            coefs[TAP_RIGHT]     = it.coef_right;
            coefs[TAP_FAR_ABOVE] = it.coef_far_above;
            acc = '0;
            for (t = 0; t < TAP_COUNT; t++)
            begin
                j = int'(it.index) + tap_offset(t);
                if (j >= 0 && j < size)
                begin
                    coef = coefs[t];
                    elem = vec_mem[j];
                    acc  = acc + coef * elem;
                end
            end
            // floor to Q16.16, then clip
            q = acc >>> FRAC_W;
            if (q > Q16_MAX)
            begin
                r.result_value = 32'sh7FFFFFFF;
                r.saturated    = 1'b1;
            end
            else if (q < Q16_MIN)
            begin
                r.result_value = 32'sh80000000;
                r.saturated    = 1'b1;
            end
            else
                r.result_value = q[DATA_W-1:0];
            return r;
        endfunction

        function void note_item(in_item_t it);
            if (it.cmd == CMD_LOAD)
            begin
                vec_mem[it.index] = it.vec_value;
                loaded[it.index]  = 1'b1;
                loads++;
            end
            else
            begin
                rows_due.push_back(stencil_row(it));
                computes++;
            end
        endfunction

        task report(string what);
            mismatches++;
            $display("tb: mismatch: %s", what);
        endtask

        task check_result(out_item_t got);
            out_item_t want;
            if (rows_due.size() == 0)
            begin
                report($sformatf("result for row %0d with no row pending", got.row));
                return;
            end
            want = rows_due.pop_front();
            if (got.row !== want.row)
                report($sformatf("row got %0d want %0d", got.row, want.row));
            if (got.result_value !== want.result_value)
                report($sformatf("row %0d value got %h want %h",
                                 want.row, got.result_value, want.result_value));
            if (got.saturated !== want.saturated)
                report($sformatf("row %0d saturated got %b want %b",
                                 want.row, got.saturated, want.saturated));
            if (got.row_error !== want.row_error)
                report($sformatf("row %0d row_error got %b want %b",
                                 want.row, got.row_error, want.row_error));
            rows_checked++;
            if (want.row_error)
                row_errors++;
            if (want.saturated)
                clipped++;
        endtask
    endclass
endpackage

FILE: verif/testbench.sv
// Top-level testbench for the pentadiagonal stencil SpMV core
`timescale 1ns / 1ps
module testbench;
    import pdss_pkg::*;
    import stencil_scoreboard_pkg::*;

    localparam int                     CYCLE_LIMIT = 400000;
    localparam int                     TAIL_CYCLES = 12;
    localparam logic [CFG_INDEX_W-1:0] REG_SPARE   = 4'd9;

    logic                   clk       = 1'b0;
    logic                   rst_n     = 1'b0;
    logic                   start     = 1'b0;
    logic                   busy;
    in_item_t               item      = '0;
    logic                   done;
    out_item_t              result;
    logic                   cfg_valid = 1'b0;
    logic                   cfg_ready;
    logic [CFG_INDEX_W-1:0] cfg_index = '0;
    logic [CFG_DATA_W-1:0]  cfg_data  = '0;

    stencil_scoreboard sb;
    int                cycles     = 0;
    int                burst_left = 0;
    int                reg_writes = 0;
    int                round;

    pentadiagonal_stencil_spmv_core i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .busy      (busy),
        .item      (item),
        .done      (done),
        .result    (result),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("tb: failure");
            $finish;
        end
    end

    always @(posedge clk)
        if (rst_n && done)
            sb.check_result(result);

    function automatic logic signed [DATA_W-1:0] rand_q();
        case ($urandom_range(0, 9))
            0:
                case ($urandom_range(0, 3))
                    0:       return 32'sh80000000;
                    1:       return 32'sh7FFFFFFF;
                    2:       return '0;
                    default: return '1;
                endcase
            1, 2, 3, 4: return DATA_W'(int'($urandom_range(0, 524288)) - 262144);
            5, 6, 7:    return DATA_W'(int'($urandom_range(0, 33554432)) - 16777216);
            default:    return $urandom;
        endcase
    endfunction

    function automatic in_item_t load_item(int idx, logic signed [DATA_W-1:0] v);
        in_item_t it;
        it.cmd            = CMD_LOAD;
        it.index          = idx[INDEX_W-1:0];
        it.vec_value      = v;
        it.coef_far_below = $urandom;
        it.coef_left      = $urandom;
        it.coef_center    = $urandom;
        it.coef_right     = $urandom;
        it.coef_far_above = $urandom;
        return it;
    endfunction

    function automatic in_item_t row_item(int r, logic signed [DATA_W-1:0] fb,
                                          logic signed [DATA_W-1:0] lf,
                                          logic signed [DATA_W-1:0] ct,
                                          logic signed [DATA_W-1:0] rt,
                                          logic signed [DATA_W-1:0] fa);
        in_item_t it;
        it.cmd            = CMD_COMPUTE;
        it.index          = r[INDEX_W-1:0];
        it.vec_value      = $urandom;
        it.coef_far_below = fb;
        it.coef_left      = lf;
        it.coef_center    = ct;
        it.coef_right     = rt;
        it.coef_far_above = fa;
        return it;
    endfunction

    // bursts of items with random gaps; start held high within a burst
    task automatic send_item(input in_item_t it);
        if (burst_left == 0)
        begin
            burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 60)
                                                     : $urandom_range(1, 8);
            start <= 1'b0;
            repeat ($urandom_range(1, 9)) @(posedge clk);
        end
        burst_left--;
        start <= 1'b1;
        item  <= it;
        do
            @(posedge clk);
        while (busy);
        sb.note_item(it);
    endtask

    // loads any in-range neighbour not yet written (in-range rows only), then the row itself
    task automatic run_row(input in_item_t it);
        int size;
        int j;
        int t;
        size = sb.live_size();
        if (int'(it.index) < size)
            for (t = 0; t < TAP_COUNT; t++)
            begin
                j = int'(it.index) + sb.tap_offset(t);
                if (j >= 0 && j < size && !sb.loaded[j])
                    send_item(load_item(j, rand_q()));
            end
        send_item(it);
    endtask

    task automatic settle();
        start <= 1'b0;
        while (sb.rows_due.size() != 0)
            @(posedge clk);
        repeat (TAIL_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        do
            @(posedge clk);
        while (!cfg_ready);
        cfg_valid <= 1'b0;
        sb.set_reg(idx, data);
        reg_writes++;
        @(posedge clk);
    endtask

    task automatic random_phase(input int n_items);
        int stop_at;
        int size;
        int r;
        stop_at = sb.loads + sb.computes + n_items;
        while (sb.loads + sb.computes < stop_at)
        begin
            size = sb.live_size();
            if ($urandom_range(0, 9) < 3)
                send_item(load_item($urandom_range(0, DEF_MAX_ELEMENTS - 1), rand_q()));
            else
            begin
                if (size == 0 || (size < DEF_MAX_ELEMENTS && $urandom_range(0, 7) == 0))
                    r = $urandom_range(size, DEF_MAX_ELEMENTS - 1);
                else
                    r = $urandom_range(0, size - 1);
                run_row(row_item(r, rand_q(), rand_q(), rand_q(), rand_q(), rand_q()));
            end
        end
    endtask

    initial
    begin
        sb = new();
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed, reset settings: corner rows and extreme values
        send_item(load_item(0, 32'sh80000000));
        send_item(load_item(1, 32'sh7FFFFFFF));
        send_item(load_item(64, '1));
        send_item(load_item(4095, 32'sh00010000));
        send_item(load_item(4094, 32'sh00018000));
        send_item(load_item(4031, '0));
        run_row(row_item(0, $urandom, $urandom, 32'sh80000000, 32'sh7FFFFFFF, 1));
        run_row(row_item(0, $urandom, $urandom, 32'sh7FFFFFFF, '0, '0));
        run_row(row_item(0, $urandom, $urandom, '0, '0, 32'sh00010000));
        run_row(row_item(4095, 32'sh00010000, 32'sh00020000, 32'sh00010000,
                         32'sh80000000, 32'sh7FFFFFFF));
        run_row(row_item(4095, '0, 1, '1, $urandom, $urandom));
        run_row(row_item(4095, '0, '1, '0, $urandom, $urandom));
        run_row(row_item(1, rand_q(), rand_q(), rand_q(), rand_q(), rand_q()));
        random_phase(60);

        settle();
        write_reg(REG_VEC_SIZE, 13'd16);
        write_reg(REG_STRIDE, 13'd4);
        random_phase(50);
        settle();
        random_phase(20);

        settle();
        write_reg(REG_VEC_SIZE, 13'd1);
        write_reg(REG_STRIDE, 13'd1);
        random_phase(20);

        settle();
        write_reg(REG_VEC_SIZE, 13'd0);
        random_phase(15);

        // unknown index must be ignored; oversized size, widest stride
        settle();
        write_reg(REG_SPARE, 13'h1FFF);
        write_reg(REG_VEC_SIZE, 13'h1FFF);
        write_reg(REG_STRIDE, 13'h1FFF);
        random_phase(50);

        settle();
        write_reg(REG_VEC_SIZE, 13'd40);
        write_reg(REG_STRIDE, 13'd0);
        random_phase(50);

        settle();
        write_reg(REG_VEC_SIZE, 13'd4096);
        write_reg(REG_STRIDE, 13'd4095);
        random_phase(30);

        for (round = 0; round < 4; round++)
        begin
            settle();
            write_reg(REG_VEC_SIZE, 13'($urandom_range(2, 64)));
            write_reg(REG_STRIDE, 13'($urandom_range(0, 12)));
            random_phase(40);
        end

        settle();
        $display("tb: %0d loads and %0d row items over %0d register writes",
                 sb.loads, sb.computes, reg_writes);
        $display("tb: %0d rows checked, %0d clipped, %0d beyond vec_size",
                 sb.rows_checked, sb.clipped, sb.row_errors);
        if (sb.mismatches == 0 && sb.rows_due.size() == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end
endmodule

FILE: pentadiagonal_stencil_spmv_core.f
+incdir+design
design/pdss_pkg.sv
design/pdss_lane.sv
design/pdss_merge.sv
design/pentadiagonal_stencil_spmv_core.sv
verif/stencil_scoreboard_pkg.sv
verif/testbench.sv
